@@ hdl/fca_pkg.sv @@
// ----------------------------------------------------------------------------
// fca_pkg
// Shared types and constants for the chain allocator: table geometry,
// operation and status codes, sequencer states and inter-module structs.
// ----------------------------------------------------------------------------
package fca_pkg;

    // Table geometry
    localparam int TABLE_ENTRIES = 256;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);
    localparam int STEPS_W       = 8;
    localparam int CMP_W         = (CNT_W > STEPS_W) ? CNT_W : STEPS_W;

    // Link markers
    localparam logic [15:0] END_MARK  = 16'hFFFF;
    localparam logic [15:0] FREE_MARK = 16'h0000;

    typedef enum logic [2:0] {
        MODE_LOAD  = 3'd0,
        MODE_READ  = 3'd1,
        MODE_ALLOC = 3'd2,
        MODE_WALK  = 3'd3,
        MODE_FREE  = 3'd4
    } t_mode;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_NOSPACE = 3'd1,
        ST_EARLY   = 3'd2,
        ST_BAD     = 3'd3,
        ST_LOOP    = 3'd4
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_READ,
        S_SCAN,
        S_LINK,
        S_WALK_CHK,
        S_WALK_DATA,
        S_FREE_CHK,
        S_FREE_DATA
    } t_state;

    // Flags from the shared compare and increment unit
    typedef struct packed {
        logic             is_end;
        logic             is_free;
        logic             in_range;
        logic             below_steps;
        logic             at_limit;
        logic [CNT_W-1:0] count_inc;
    } t_flags;

    // Table port request
    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] addr;
        logic [15:0]      wdata;
    } t_mem_req;

    // One result item
    typedef struct packed {
        logic        done;
        t_status     status;
        logic [15:0] block;
        logic [15:0] value;
    } t_result;

endpackage

@@ hdl/fca_unit.sv @@
// ----------------------------------------------------------------------------
// fca_unit
// Shared compare and increment unit: classifies a link word and advances
// whichever counter the sequencer is currently stepping.
// ----------------------------------------------------------------------------
module fca_unit (
    input  logic [15:0]                 i_word,
    input  logic [fca_pkg::CNT_W-1:0]   i_count,
    input  logic [fca_pkg::STEPS_W-1:0] i_steps,
    output fca_pkg::t_flags             o_flags
);

    // Marker and range checks on the link word.
    assign o_flags.is_end   = (i_word == fca_pkg::END_MARK);
    assign o_flags.is_free  = (i_word == fca_pkg::FREE_MARK);
    assign o_flags.in_range = ({1'b0, i_word} < 17'(fca_pkg::TABLE_ENTRIES));

    // Counter compares and the single incrementer.
    assign o_flags.below_steps = (fca_pkg::CMP_W'(i_count) < fca_pkg::CMP_W'(i_steps));
    assign o_flags.at_limit    = (i_count >= fca_pkg::CNT_W'(fca_pkg::TABLE_ENTRIES));
    assign o_flags.count_inc   = i_count + fca_pkg::CNT_W'(1);

endmodule

@@ hdl/fca_table.sv @@
// ----------------------------------------------------------------------------
// fca_table
// Link table storage: single-port memory with a registered read.
// Contents are not initialised; every entry is undefined until written.
// ----------------------------------------------------------------------------
module fca_table (
    input  logic              i_clk,
    input  fca_pkg::t_mem_req i_req,
    output logic [15:0]       o_rdata
);

    logic [15:0] r_mem [fca_pkg::TABLE_ENTRIES];
    logic [15:0] r_rdata;

    // Write when requested; the read returns the old contents next cycle.
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.addr] <= i_req.wdata;
        end
        r_rdata <= r_mem[i_req.addr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/fca_ctrl.sv @@
// ----------------------------------------------------------------------------
// fca_ctrl
// Sequencer for the chain allocator. Decodes the operation, scans the
// table for a free entry, and follows or releases chains one link at a time
// using the shared compare and increment unit.
// ----------------------------------------------------------------------------
module fca_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_accept,
    input  logic [2:0]                  i_mode,
    input  logic [15:0]                 i_block,
    input  logic [15:0]                 i_value,
    input  logic [fca_pkg::STEPS_W-1:0] i_steps,
    input  logic                        i_link_tail,
    input  logic [15:0]                 i_rdata,
    output logic                        o_busy,
    output fca_pkg::t_mem_req           o_req,
    output fca_pkg::t_result            o_res
);

    fca_pkg::t_state r_state, n_state;
    fca_pkg::t_mode  r_mode,  n_mode;
    logic [15:0]                 r_blk,   n_blk;
    logic [15:0]                 r_val,   n_val;
    logic [fca_pkg::STEPS_W-1:0] r_steps, n_steps;
    logic                        r_tail,  n_tail;
    logic                        r_link,  n_link;
    logic [15:0]                 r_cur,   n_cur;
    logic [fca_pkg::CNT_W-1:0]   r_n,     n_n;
    logic [fca_pkg::CNT_W-1:0]   r_idx,   n_idx;
    logic [fca_pkg::IDX_W-1:0]   r_chk,   n_chk;
    logic                        r_pend,  n_pend;

    logic [15:0]               unit_word;
    logic [fca_pkg::CNT_W-1:0] unit_count;
    fca_pkg::t_flags           flags;

    // The scan checks returned words and steps the scan index; everything
    // else checks the current link and steps the link counter.
    assign unit_word  = (r_state == fca_pkg::S_SCAN) ? i_rdata : r_cur;
    assign unit_count = (r_state == fca_pkg::S_SCAN) ? r_idx : r_n;

    fca_unit u_unit (
        .i_word  (unit_word),
        .i_count (unit_count),
        .i_steps (r_steps),
        .o_flags (flags)
    );

    // State register; only the state and the scan pending flag need reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fca_pkg::S_IDLE;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend  <= n_pend;
        end
    end

    // Working registers of the current item.
    always_ff @(posedge i_clk) begin
        r_mode  <= n_mode;
        r_blk   <= n_blk;
        r_val   <= n_val;
        r_steps <= n_steps;
        r_tail  <= n_tail;
        r_link  <= n_link;
        r_cur   <= n_cur;
        r_n     <= n_n;
        r_idx   <= n_idx;
        r_chk   <= n_chk;
    end

    // Next state, table requests and result.
    always_comb begin
        n_state = r_state;
        n_mode  = r_mode;
        n_blk   = r_blk;
        n_val   = r_val;
        n_steps = r_steps;
        n_tail  = r_tail;
        n_link  = r_link;
        n_cur   = r_cur;
        n_n     = r_n;
        n_idx   = r_idx;
        n_chk   = r_chk;
        n_pend  = r_pend;
        o_req   = '0;
        o_res   = '0;

        case (r_state)
            fca_pkg::S_IDLE: begin
                if (i_accept) begin
                    n_mode  = fca_pkg::t_mode'(i_mode);
                    n_blk   = i_block;
                    n_cur   = i_block;
                    n_val   = i_value;
                    n_steps = i_steps;
                    n_tail  = i_link_tail;
                    n_n     = '0;
                    n_state = fca_pkg::S_DECODE;
                end
            end

            fca_pkg::S_DECODE: begin
                n_state = fca_pkg::S_IDLE;
                case (r_mode)
                    fca_pkg::MODE_LOAD: begin
                        o_res.done  = 1'b1;
                        o_res.block = r_blk;
                        if (!flags.in_range) begin
                            o_res.status = fca_pkg::ST_BAD;
                        end else begin
                            o_req.we     = 1'b1;
                            o_req.addr   = r_cur[fca_pkg::IDX_W-1:0];
                            o_req.wdata  = r_val;
                            o_res.status = fca_pkg::ST_OK;
                            o_res.value  = r_val;
                        end
                    end
                    fca_pkg::MODE_READ: begin
                        if (!flags.in_range) begin
                            o_res.done   = 1'b1;
                            o_res.status = fca_pkg::ST_BAD;
                            o_res.block  = r_blk;
                        end else begin
                            o_req.addr = r_cur[fca_pkg::IDX_W-1:0];
                            n_state    = fca_pkg::S_READ;
                        end
                    end
                    fca_pkg::MODE_ALLOC: begin
                        if (r_tail && !flags.is_end && !flags.in_range) begin
                            o_res.done   = 1'b1;
                            o_res.status = fca_pkg::ST_BAD;
                        end else begin
                            n_link  = r_tail && !flags.is_end;
                            n_idx   = fca_pkg::CNT_W'(1);
                            n_pend  = 1'b0;
                            n_state = fca_pkg::S_SCAN;
                        end
                    end
                    fca_pkg::MODE_WALK: begin
                        n_state = fca_pkg::S_WALK_CHK;
                    end
                    fca_pkg::MODE_FREE: begin
                        n_state = fca_pkg::S_FREE_CHK;
                    end
                    default: begin
                        // Unused operation codes change nothing.
                        o_res.done = 1'b1;
                    end
                endcase
            end

            fca_pkg::S_READ: begin
                o_res.done   = 1'b1;
                o_res.status = fca_pkg::ST_OK;
                o_res.block  = r_blk;
                o_res.value  = i_rdata;
                n_state      = fca_pkg::S_IDLE;
            end

            // One read issued per cycle, checked in the next cycle.
            fca_pkg::S_SCAN: begin
                if (r_pend && flags.is_free) begin
                    o_req.we    = 1'b1;
                    o_req.addr  = r_chk;
                    o_req.wdata = fca_pkg::END_MARK;
                    n_pend      = 1'b0;
                    if (r_link) begin
                        n_state = fca_pkg::S_LINK;
                    end else begin
                        o_res.done   = 1'b1;
                        o_res.status = fca_pkg::ST_OK;
                        o_res.block  = 16'(r_chk);
                        n_state      = fca_pkg::S_IDLE;
                    end
                end else if (r_idx == fca_pkg::CNT_W'(fca_pkg::TABLE_ENTRIES)) begin
                    o_res.done   = 1'b1;
                    o_res.status = fca_pkg::ST_NOSPACE;
                    n_pend       = 1'b0;
                    n_state      = fca_pkg::S_IDLE;
                end else begin
                    o_req.addr = r_idx[fca_pkg::IDX_W-1:0];
                    n_chk      = r_idx[fca_pkg::IDX_W-1:0];
                    n_pend     = 1'b1;
                    n_idx      = flags.count_inc;
                end
            end

            // The tail link goes in after the claim, so a free tail that
            // was itself taken ends up pointing to itself.
            fca_pkg::S_LINK: begin
                o_req.we     = 1'b1;
                o_req.addr   = r_blk[fca_pkg::IDX_W-1:0];
                o_req.wdata  = 16'(r_chk);
                o_res.done   = 1'b1;
                o_res.status = fca_pkg::ST_OK;
                o_res.block  = 16'(r_chk);
                n_state      = fca_pkg::S_IDLE;
            end

            fca_pkg::S_WALK_CHK: begin
                o_res.block = r_cur;
                o_res.value = 16'(r_n);
                if (flags.is_end) begin
                    o_res.done   = 1'b1;
                    o_res.status = flags.below_steps ? fca_pkg::ST_EARLY : fca_pkg::ST_OK;
                    n_state      = fca_pkg::S_IDLE;
                end else if (!flags.in_range) begin
                    o_res.done   = 1'b1;
                    o_res.status = fca_pkg::ST_BAD;
                    n_state      = fca_pkg::S_IDLE;
                end else if (!flags.below_steps) begin
                    o_res.done   = 1'b1;
                    o_res.status = fca_pkg::ST_OK;
                    n_state      = fca_pkg::S_IDLE;
                end else if (flags.at_limit) begin
                    o_res.done   = 1'b1;
                    o_res.status = fca_pkg::ST_LOOP;
                    n_state      = fca_pkg::S_IDLE;
                end else begin
                    o_req.addr = r_cur[fca_pkg::IDX_W-1:0];
                    n_state    = fca_pkg::S_WALK_DATA;
                end
            end

            fca_pkg::S_WALK_DATA: begin
                n_cur   = i_rdata;
                n_n     = flags.count_inc;
                n_state = fca_pkg::S_WALK_CHK;
            end

            fca_pkg::S_FREE_CHK: begin
                o_res.block = r_cur;
                o_res.value = 16'(r_n);
                if (flags.is_end || flags.is_free) begin
                    o_res.done   = 1'b1;
                    o_res.status = fca_pkg::ST_OK;
                    n_state      = fca_pkg::S_IDLE;
                end else if (!flags.in_range) begin
                    o_res.done   = 1'b1;
                    o_res.status = fca_pkg::ST_BAD;
                    n_state      = fca_pkg::S_IDLE;
                end else if (flags.at_limit) begin
                    o_res.done   = 1'b1;
                    o_res.status = fca_pkg::ST_LOOP;
                    n_state      = fca_pkg::S_IDLE;
                end else begin
                    o_req.addr = r_cur[fca_pkg::IDX_W-1:0];
                    n_state    = fca_pkg::S_FREE_DATA;
                end
            end

            // Release the entry just read and move on to its successor.
            fca_pkg::S_FREE_DATA: begin
                o_req.we    = 1'b1;
                o_req.addr  = r_cur[fca_pkg::IDX_W-1:0];
                o_req.wdata = fca_pkg::FREE_MARK;
                n_cur       = i_rdata;
                n_n         = flags.count_inc;
                n_state     = fca_pkg::S_FREE_CHK;
            end

            default: begin
                n_state = fca_pkg::S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != fca_pkg::S_IDLE);

endmodule

@@ hdl/fat_chain_allocator.sv @@
// ----------------------------------------------------------------------------
// fat_chain_allocator
// File allocation table of 16-bit next-block links with load, read,
// allocate, chain walk and chain free operations.
// ----------------------------------------------------------------------------
// Allocation scans the table from index 1, one table read per cycle, up to
// the first free entry and then links the tail when one is given; walk and
// free cost a read and a check for each link they follow.
// One item at a time: busy is high from accept until the result strobe.
// Synchronous reset clears the sequencer and the result strobe register;
// table contents stay undefined.
module fat_chain_allocator (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [2:0]                  i_mode,
    input  logic [15:0]                 i_block,
    input  logic [15:0]                 i_value,
    input  logic [fca_pkg::STEPS_W-1:0] i_steps,
    input  logic                        i_link_tail,
    output logic                        o_done,
    output logic [2:0]                  o_status,
    output logic [15:0]                 o_block_out,
    output logic [15:0]                 o_value_out
);

    fca_pkg::t_mem_req req;
    fca_pkg::t_result  res;
    logic [15:0]       rdata;
    logic              ctrl_busy;

    logic        r_done;
    logic [2:0]  r_status;
    logic [15:0] r_block_out;
    logic [15:0] r_value_out;

    fca_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (start && !ctrl_busy),
        .i_mode      (i_mode),
        .i_block     (i_block),
        .i_value     (i_value),
        .i_steps     (i_steps),
        .i_link_tail (i_link_tail),
        .i_rdata     (rdata),
        .o_busy      (ctrl_busy),
        .o_req       (req),
        .o_res       (res)
    );

    fca_table u_table (
        .i_clk   (i_clk),
        .i_req   (req),
        .o_rdata (rdata)
    );

    // Result register: the strobe lasts exactly one cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= res.done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res.done) begin
            r_status    <= 3'(res.status);
            r_block_out <= res.block;
            r_value_out <= res.value;
        end
    end

    assign busy        = ctrl_busy;
    assign o_done      = r_done;
    assign o_status    = r_status;
    assign o_block_out = r_block_out;
    assign o_value_out = r_value_out;

endmodule

@@ hdl/fca_checker.sv @@
// ----------------------------------------------------------------------------
// fca_checker
// Port-level checks on the command handshake and result strobe of the
// chain allocator, bound to the top level.
// ----------------------------------------------------------------------------
module fca_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic [2:0]  i_mode,
    input logic [15:0] i_block,
    input logic        o_done,
    input logic [2:0]  o_status
);

    // An accepted item keeps the block busy in the following cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("block not busy after an accepted item");

    // The result strobe is a single-cycle pulse.
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe longer than one cycle");

    // A result only follows work in progress, and the block is free again.
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ($past(busy) && !busy))
        else $error("result strobe without a preceding busy period");

    // An out-of-range load or read index is flagged bad in decode and registered.
    a_bad_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_mode == 3'(fca_pkg::MODE_LOAD) ||
                            i_mode == 3'(fca_pkg::MODE_READ)) &&
         ({1'b0, i_block} >= 17'(fca_pkg::TABLE_ENTRIES)))
        |-> ##2 (o_done && o_status == 3'(fca_pkg::ST_BAD)))
        else $error("out-of-range index not reported as bad");

endmodule

bind fat_chain_allocator fca_checker u_fca_checker (.*);

@@ verif/tb_fat_chain_allocator.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_fat_chain_allocator
// Self-checking bench for the chain allocator. Every table entry is written
// first, so no operation ever reads an undefined link. A short directed
// sequence then covers the corner cases, followed by random chain building,
// walking and freeing. Each accepted item is run through a behavioural copy
// of the table, and every result strobe is checked field by field.
// ----------------------------------------------------------------------------
module tb;

    localparam int CLK_PERIOD     = 20;
    localparam int RESET_CYCLES   = 11;
    localparam int RANDOM_ITEMS   = 1460;
    localparam int IDLE_PERCENT   = 24;
    localparam int QUIET_FROM     = 800;
    localparam int QUIET_TO       = 1100;
    localparam int SETTLE_CYCLES  = 600;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int REPORT_LIMIT   = 10;
    localparam int MAX_HEADS      = 12;
    localparam int PLAN_SIDE      = 0;
    localparam int LIVE_SIDE      = 1;

    typedef struct {
        logic [2:0]                  mode;
        logic [15:0]                 blk;
        logic [15:0]                 val;
        logic [fca_pkg::STEPS_W-1:0] steps;
        logic                        tail;
        bit                          drain_first;
    } t_fat_req;

    typedef struct {
        fca_pkg::t_status status;
        logic [15:0]      block_out;
        logic [15:0]      value_out;
    } t_fat_resp;

    logic                        i_clk       = 1'b0;
    logic                        i_rst_n     = 1'b0;
    logic                        start       = 1'b0;
    logic                        busy;
    logic [2:0]                  i_mode      = '0;
    logic [15:0]                 i_block     = '0;
    logic [15:0]                 i_value     = '0;
    logic [fca_pkg::STEPS_W-1:0] i_steps     = '0;
    logic                        i_link_tail = 1'b0;
    logic                        o_done;
    logic [2:0]                  o_status;
    logic [15:0]                 o_block_out;
    logic [15:0]                 o_value_out;

    // Two copies of the link table: one steers the stimulus while it is
    // generated, the other tracks the block as items are accepted.
    logic [15:0] link_copy [2][fca_pkg::TABLE_ENTRIES];
    t_fat_req    pending_q [$];
    t_fat_resp   expected_q [$];

    int outstanding  = 0;
    int accepted_n   = 0;
    int results_n    = 0;
    int error_count  = 0;
    int idle_run     = 0;
    int mode_tally   [8] = '{default: 0};
    int status_tally [8] = '{default: 0};

    fat_chain_allocator dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_mode      (i_mode),
        .i_block     (i_block),
        .i_value     (i_value),
        .i_steps     (i_steps),
        .i_link_tail (i_link_tail),
        .o_done      (o_done),
        .o_status    (o_status),
        .o_block_out (o_block_out),
        .o_value_out (o_value_out)
    );

    // Clock and a single reset pulse at the start of the run.
    initial begin
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Applies one operation to the chosen table copy and returns its result.
    function automatic t_fat_resp fat_apply(input int side, input t_fat_req rq);
        t_fat_resp   r;
        int unsigned cur;
        int unsigned hops;
        int unsigned k;
        int unsigned got;
        logic [15:0] nxt;
        bit          going;
        r.status    = fca_pkg::ST_OK;
        r.block_out = '0;
        r.value_out = '0;
        case (rq.mode)
            fca_pkg::MODE_LOAD: begin
                if (rq.blk >= fca_pkg::TABLE_ENTRIES) begin
                    r.status    = fca_pkg::ST_BAD;
                    r.block_out = rq.blk;
                end else begin
                    link_copy[side][rq.blk] = rq.val;
                    r.block_out = rq.blk;
                    r.value_out = rq.val;
                end
            end
            fca_pkg::MODE_READ: begin
                r.block_out = rq.blk;
                if (rq.blk >= fca_pkg::TABLE_ENTRIES)
                    r.status = fca_pkg::ST_BAD;
                else
                    r.value_out = link_copy[side][rq.blk];
            end
            fca_pkg::MODE_ALLOC: begin
                if (rq.tail && rq.blk != fca_pkg::END_MARK &&
                    rq.blk >= fca_pkg::TABLE_ENTRIES) begin
                    r.status = fca_pkg::ST_BAD;
                end else begin
                    // Lowest free entry from index 1; entry 0 is never handed out.
                    got = 0;
                    for (k = 1; k < fca_pkg::TABLE_ENTRIES && got == 0; k++)
                        if (link_copy[side][k] == fca_pkg::FREE_MARK)
                            got = k;
                    if (got == 0) begin
                        r.status = fca_pkg::ST_NOSPACE;
                    end else begin
                        link_copy[side][got] = fca_pkg::END_MARK;
                        // The link goes in after the claim, so a free tail
                        // that is itself taken ends up pointing at itself.
                        if (rq.tail && rq.blk != fca_pkg::END_MARK)
                            link_copy[side][rq.blk] = 16'(got);
                        r.block_out = 16'(got);
                    end
                end
            end
            fca_pkg::MODE_WALK: begin
                cur   = rq.blk;
                hops  = 0;
                going = 1'b1;
                while (going) begin
                    if (cur == fca_pkg::END_MARK) begin
                        if (hops < rq.steps)
                            r.status = fca_pkg::ST_EARLY;
                        going = 1'b0;
                    end else if (cur >= fca_pkg::TABLE_ENTRIES) begin
                        r.status = fca_pkg::ST_BAD;
                        going    = 1'b0;
                    end else if (hops >= rq.steps) begin
                        going = 1'b0;
                    end else if (hops >= fca_pkg::TABLE_ENTRIES) begin
                        r.status = fca_pkg::ST_LOOP;
                        going    = 1'b0;
                    end else begin
                        cur = link_copy[side][cur];
                        hops++;
                    end
                end
                r.block_out = 16'(cur);
                r.value_out = 16'(hops);
            end
            fca_pkg::MODE_FREE: begin
                cur   = rq.blk;
                hops  = 0;
                going = 1'b1;
                while (going) begin
                    if (cur == fca_pkg::END_MARK || cur == fca_pkg::FREE_MARK) begin
                        going = 1'b0;
                    end else if (cur >= fca_pkg::TABLE_ENTRIES) begin
                        r.status = fca_pkg::ST_BAD;
                        going    = 1'b0;
                    end else if (hops >= fca_pkg::TABLE_ENTRIES) begin
                        r.status = fca_pkg::ST_LOOP;
                        going    = 1'b0;
                    end else begin
                        nxt = link_copy[side][cur];
                        link_copy[side][cur] = fca_pkg::FREE_MARK;
                        hops++;
                        cur = nxt;
                    end
                end
                r.block_out = 16'(cur);
                r.value_out = 16'(hops);
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    // Appends an item to the send queue and keeps the planning table in step.
    task automatic queue_op(input logic [2:0] md, input logic [15:0] bk,
                            input logic [15:0] vl,
                            input logic [fca_pkg::STEPS_W-1:0] st,
                            input logic tl, input bit drain, output t_fat_resp rs);
        t_fat_req rq;
        rq.mode        = md;
        rq.blk         = bk;
        rq.val         = vl;
        rq.steps       = st;
        rq.tail        = tl;
        rq.drain_first = drain;
        rs = fat_apply(PLAN_SIDE, rq);
        pending_q.push_back(rq);
    endtask

    task automatic flag_error(input string msg);
        if (error_count < REPORT_LIMIT)
            $display("ERROR: %s", msg);
        error_count++;
    endtask

    // Item driver: presents queued items, idles at random outside the quiet
    // stretch, and holds an item marked for draining until nothing is owed.
    always @(posedge i_clk) begin : item_drive
        t_fat_req nxt;
        logic     offer;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!start || !busy) begin
            offer = pending_q.size() != 0;
            if (offer && !(accepted_n >= QUIET_FROM && accepted_n < QUIET_TO))
                offer = $urandom_range(0, 99) >= IDLE_PERCENT;
            if (offer && pending_q[0].drain_first)
                offer = !start && outstanding == 0;
            if (offer) begin
                nxt = pending_q.pop_front();
                i_mode      <= nxt.mode;
                i_block     <= nxt.blk;
                i_value     <= nxt.val;
                i_steps     <= nxt.steps;
                i_link_tail <= nxt.tail;
            end
            start <= offer;
        end
    end

    // Result monitor: predicts on acceptance, checks each strobe against the
    // oldest prediction, and stops the run if nothing moves for too long.
    always @(posedge i_clk) begin : result_check
        t_fat_req  rq;
        t_fat_resp want;
        logic      took;
        if (i_rst_n) begin
            took = start && !busy;
            if (o_done) begin
                if (expected_q.size() == 0) begin
                    flag_error($sformatf("result %0d arrived with nothing expected",
                                         results_n));
                end else begin
                    want = expected_q.pop_front();
                    if (o_status !== want.status)
                        flag_error($sformatf("result %0d status: expected %0d, got %0d",
                                             results_n, want.status, o_status));
                    if (o_block_out !== want.block_out)
                        flag_error($sformatf("result %0d block: expected %h, got %h",
                                             results_n, want.block_out, o_block_out));
                    if (o_value_out !== want.value_out)
                        flag_error($sformatf("result %0d value: expected %h, got %h",
                                             results_n, want.value_out, o_value_out));
                end
                results_n <= results_n + 1;
            end
            if (took) begin
                rq.mode        = i_mode;
                rq.blk         = i_block;
                rq.val         = i_value;
                rq.steps       = i_steps;
                rq.tail        = i_link_tail;
                rq.drain_first = 1'b0;
                want = fat_apply(LIVE_SIDE, rq);
                expected_q.push_back(want);
                mode_tally[i_mode]        <= mode_tally[i_mode] + 1;
                status_tally[want.status] <= status_tally[want.status] + 1;
                accepted_n                <= accepted_n + 1;
            end
            outstanding <= outstanding + (took ? 1 : 0) - (o_done ? 1 : 0);
            if (took || o_done) begin
                idle_run <= 0;
            end else if (idle_run >= WATCHDOG_LIMIT) begin
                $display("Timeout: no item or result moved for %0d cycles", idle_run);
                $display("DONE: errors detected");
                $finish;
            end else begin
                idle_run <= idle_run + 1;
            end
        end
    end

    // Stimulus and end of run.
    initial begin : stimulus
        t_fat_resp   rs;
        int unsigned heads [$];
        int unsigned n;
        int unsigned k;
        int unsigned pick;
        int unsigned cur;
        int unsigned hops;
        int unsigned lowest;
        int unsigned bucket;
        int unsigned roll;
        logic [15:0] vl;
        logic [15:0] bk;
        logic [2:0]  md;
        bit          drain;

        // Write every entry: one long chain 0 -> 1 -> ... -> last -> end.
        for (k = 0; k < fca_pkg::TABLE_ENTRIES; k++) begin
            vl = (k == fca_pkg::TABLE_ENTRIES - 1) ? fca_pkg::END_MARK : 16'(k + 1);
            queue_op(fca_pkg::MODE_LOAD, 16'(k), vl, 8'($urandom), 1'($urandom), 1'b0, rs);
        end

        // Directed: a read of entry 0, then bad indices on load and read.
        queue_op(fca_pkg::MODE_READ, 16'h0000, 16'h0000, 8'h00, 1'b0, 1'b0, rs);
        queue_op(fca_pkg::MODE_READ, 16'(fca_pkg::TABLE_ENTRIES), 16'hFFFF, 8'hFF, 1'b1,
                 1'b0, rs);
        queue_op(fca_pkg::MODE_READ, fca_pkg::END_MARK, 16'h0000, 8'h00, 1'b0, 1'b0, rs);
        queue_op(fca_pkg::MODE_LOAD, fca_pkg::END_MARK, 16'h1234, 8'h00, 1'b0, 1'b0, rs);
        queue_op(fca_pkg::MODE_LOAD, 16'h8000, 16'hFFFF, 8'h00, 1'b0, 1'b0, rs);
        // Table is full: no space, and a bad tail allocates nothing.
        queue_op(fca_pkg::MODE_ALLOC, 16'h0005, 16'h0000, 8'h00, 1'b0, 1'b0, rs);
        queue_op(fca_pkg::MODE_ALLOC, 16'(fca_pkg::TABLE_ENTRIES), 16'h0000, 8'h00, 1'b1,
                 1'b0, rs);
        // Walks: full length, part way, ending early, zero steps, bad start.
        queue_op(fca_pkg::MODE_WALK, 16'h0001, 16'h0000, 8'hFF, 1'b0, 1'b0, rs);
        queue_op(fca_pkg::MODE_WALK, 16'h0001, 16'h0000, 8'd10, 1'b0, 1'b0, rs);
        queue_op(fca_pkg::MODE_WALK, 16'd250, 16'h0000, 8'd20, 1'b0, 1'b0, rs);
        queue_op(fca_pkg::MODE_WALK, 16'h0000, 16'h0000, 8'h00, 1'b0, 1'b0, rs);
        queue_op(fca_pkg::MODE_WALK, fca_pkg::END_MARK, 16'h0000, 8'd3, 1'b0, 1'b0, rs);
        queue_op(fca_pkg::MODE_WALK, 16'h7FFF, 16'h0000, 8'd1, 1'b0, 1'b0, rs);
        // Free the long chain, then the starts that free nothing.
        queue_op(fca_pkg::MODE_FREE, 16'h0001, 16'h0000, 8'h00, 1'b0, 1'b0, rs);
        queue_op(fca_pkg::MODE_FREE, fca_pkg::FREE_MARK, 16'h0000, 8'h00, 1'b0, 1'b0, rs);
        queue_op(fca_pkg::MODE_FREE, fca_pkg::END_MARK, 16'h0000, 8'h00, 1'b0, 1'b0, rs);
        // Allocate without a tail, after a tail, with no tail given, and with
        // a free tail that is itself the entry taken.
        queue_op(fca_pkg::MODE_ALLOC, 16'h0000, 16'h0000, 8'h00, 1'b0, 1'b0, rs);
        queue_op(fca_pkg::MODE_ALLOC, 16'h0001, 16'h0000, 8'h00, 1'b1, 1'b0, rs);
        queue_op(fca_pkg::MODE_ALLOC, fca_pkg::END_MARK, 16'h0000, 8'h00, 1'b1, 1'b0, rs);
        queue_op(fca_pkg::MODE_ALLOC, 16'h0004, 16'h0000, 8'h00, 1'b1, 1'b0, rs);
        queue_op(fca_pkg::MODE_WALK, 16'h0004, 16'h0000, 8'd200, 1'b0, 1'b0, rs);
        queue_op(fca_pkg::MODE_FREE, 16'h0004, 16'h0000, 8'h00, 1'b0, 1'b0, rs);
        // A free that runs into an out-of-range link part way along.
        queue_op(fca_pkg::MODE_LOAD, 16'd10, 16'h012C, 8'h00, 1'b0, 1'b0, rs);
        queue_op(fca_pkg::MODE_LOAD, 16'd9, 16'd10, 8'h00, 1'b0, 1'b0, rs);
        queue_op(fca_pkg::MODE_FREE, 16'd9, 16'h0000, 8'h00, 1'b0, 1'b0, rs);
        // Entry 0 used as a tail, then walked through.
        queue_op(fca_pkg::MODE_ALLOC, 16'h0000, 16'h0000, 8'h00, 1'b1, 1'b0, rs);
        queue_op(fca_pkg::MODE_WALK, 16'h0000, 16'h0000, 8'd3, 1'b0, 1'b0, rs);
        // Unused modes with random fields.
        for (md = 3'(fca_pkg::MODE_FREE) + 3'd1; md != 3'(fca_pkg::MODE_LOAD); md++)
            queue_op(md, 16'($urandom), 16'($urandom), 8'($urandom), 1'($urandom), 1'b0, rs);

        // Random part: mostly chains built, walked and freed, plus noise.
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            drain  = (n == 0) || ($urandom_range(0, 199) == 0);
            bucket = $urandom_range(0, 99);
            if (rs.status == fca_pkg::ST_NOSPACE)
                bucket = 60;

            // An extension needs a chain whose end can still be found.
            if (bucket < 30) begin
                if (heads.size() == 0) begin
                    bucket = 30;
                end else begin
                    pick = $urandom_range(0, heads.size() - 1);
                    cur  = heads[pick];
                    hops = 0;
                    while (link_copy[PLAN_SIDE][cur] != fca_pkg::END_MARK &&
                           link_copy[PLAN_SIDE][cur] != fca_pkg::FREE_MARK &&
                           link_copy[PLAN_SIDE][cur] < fca_pkg::TABLE_ENTRIES &&
                           hops < fca_pkg::TABLE_ENTRIES) begin
                        cur = link_copy[PLAN_SIDE][cur];
                        hops++;
                    end
                    if (link_copy[PLAN_SIDE][cur] != fca_pkg::END_MARK) begin
                        heads.delete(pick);
                        bucket = 30;
                    end
                end
            end

            if (bucket < 30) begin
                queue_op(fca_pkg::MODE_ALLOC, 16'(cur), 16'($urandom), 8'($urandom), 1'b1,
                         drain, rs);
            end else if (bucket < 40) begin
                if (heads.size() >= MAX_HEADS) begin
                    queue_op(fca_pkg::MODE_FREE, 16'(heads.pop_front()), 16'($urandom),
                             8'($urandom), 1'($urandom), drain, rs);
                end else begin
                    roll = $urandom_range(0, 1);
                    bk   = roll ? fca_pkg::END_MARK : 16'($urandom);
                    queue_op(fca_pkg::MODE_ALLOC, bk, 16'($urandom), 8'($urandom), 1'(roll),
                             drain, rs);
                    if (rs.status == fca_pkg::ST_OK)
                        heads.push_back(rs.block_out);
                end
            end else if (bucket < 60) begin
                roll = $urandom_range(0, 99);
                if (roll < 75 && heads.size() != 0)
                    bk = 16'(heads[$urandom_range(0, heads.size() - 1)]);
                else if (roll < 90)
                    bk = 16'($urandom_range(0, fca_pkg::TABLE_ENTRIES - 1));
                else
                    bk = 16'($urandom);
                roll = $urandom_range(0, 99);
                queue_op(fca_pkg::MODE_WALK, bk, 16'($urandom),
                         (roll < 70) ? 8'($urandom_range(0, 16)) : 8'($urandom),
                         1'($urandom), drain, rs);
            end else if (bucket < 70) begin
                if (heads.size() != 0 && $urandom_range(0, 99) < 80) begin
                    pick = $urandom_range(0, heads.size() - 1);
                    bk   = 16'(heads[pick]);
                    heads.delete(pick);
                end else begin
                    bk = 16'($urandom_range(0, fca_pkg::TABLE_ENTRIES - 1));
                end
                queue_op(fca_pkg::MODE_FREE, bk, 16'($urandom), 8'($urandom), 1'($urandom),
                         drain, rs);
            end else if (bucket < 77) begin
                bk = ($urandom_range(0, 99) < 85)
                     ? 16'($urandom_range(0, fca_pkg::TABLE_ENTRIES - 1)) : 16'($urandom);
                queue_op(fca_pkg::MODE_READ, bk, 16'($urandom), 8'($urandom), 1'($urandom),
                         drain, rs);
            end else if (bucket < 85) begin
                bk   = ($urandom_range(0, 99) < 90)
                       ? 16'($urandom_range(0, fca_pkg::TABLE_ENTRIES - 1)) : 16'($urandom);
                roll = $urandom_range(0, 99);
                if (roll < 40)
                    vl = fca_pkg::FREE_MARK;
                else if (roll < 55)
                    vl = fca_pkg::END_MARK;
                else if (roll < 80)
                    vl = 16'($urandom_range(0, fca_pkg::TABLE_ENTRIES - 1));
                else
                    vl = 16'($urandom);
                queue_op(fca_pkg::MODE_LOAD, bk, vl, 8'($urandom), 1'($urandom), drain, rs);
            end else if (bucket < 90) begin
                // Odd tails: the entry about to be taken, or any entry at all.
                lowest = 0;
                for (k = 1; k < fca_pkg::TABLE_ENTRIES && lowest == 0; k++)
                    if (link_copy[PLAN_SIDE][k] == fca_pkg::FREE_MARK)
                        lowest = k;
                if (lowest != 0 && $urandom_range(0, 1))
                    bk = 16'(lowest);
                else
                    bk = 16'($urandom_range(0, fca_pkg::TABLE_ENTRIES - 1));
                queue_op(fca_pkg::MODE_ALLOC, bk, 16'($urandom), 8'($urandom), 1'b1,
                         drain, rs);
            end else begin
                queue_op(3'($urandom), 16'($urandom), 16'($urandom), 8'($urandom),
                         1'($urandom), drain, rs);
            end
        end

        // Wait for every item to go in and every result to come back.
        while (pending_q.size() != 0 || start || outstanding != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (expected_q.size() != 0)
            flag_error($sformatf("%0d results never arrived", expected_q.size()));

        $display("Covered %0d items: %0d loads, %0d reads, %0d allocations, %0d walks, %0d frees",
                 accepted_n, mode_tally[fca_pkg::MODE_LOAD], mode_tally[fca_pkg::MODE_READ],
                 mode_tally[fca_pkg::MODE_ALLOC], mode_tally[fca_pkg::MODE_WALK],
                 mode_tally[fca_pkg::MODE_FREE]);
        $display("Outcomes: %0d ok, %0d no space, %0d early end, %0d bad index; %0d mismatches",
                 status_tally[fca_pkg::ST_OK], status_tally[fca_pkg::ST_NOSPACE],
                 status_tally[fca_pkg::ST_EARLY], status_tally[fca_pkg::ST_BAD], error_count);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
